### rtl/core/psg_pkg.sv
// shared types and constants of the tone and noise sound generator
package psg_pkg;

    // attenuation steps in thousandths of the peak level, silent at the last step
    localparam int unsigned ATTEN_RATIO [16] = '{
        1000, 794, 631, 501, 398, 316, 251, 200,
        158, 126, 100, 79, 63, 50, 40, 0
    };
    localparam int unsigned RATIO_SCALE = 1000;

    localparam logic [1:0]  CH_NOISE          = 2'd3;
    localparam logic [1:0]  RATE_FROM_TONE2   = 2'd3;
    localparam logic [15:0] NOISE_SEED        = 16'h8000;
    localparam logic [9:0]  NOISE_BASE_RELOAD = 10'h010;
    localparam logic [3:0]  ATTEN_SILENT      = 4'hf;

    // what one counter reports to the top level on a tick
    typedef struct packed {
        logic toggle;  // counter expired and reloaded
        logic square;  // square output after this tick
    } t_chan_status;

endpackage

### rtl/core/psg_tone_noise_generator_top.sv
// top level of the three-tone, one-noise sound generator
//
// usage
//   slave channel: one item per handshake, tuser[0] picks the kind
//     0 = register write, tdata[7:0] is the command or data byte
//     1 = generator tick, tdata ignored
//   master channel: one item per tick, tdata[14:0] is the summed level
//     of all four channels after that tick; writes return nothing
//   a tick passes from the input register to the output register; throughput:
//     one item per clock while not stalled, set by the single update stage
//     that steps the four counters and the noise shifter and sums the levels
//   writes and ticks go through the same input register, so their order
//     is kept exactly
//   stall: a level waiting on the master side holds; one more item sits in
//     the input register, then tready drops. writes still drain while the
//     output waits, since they produce nothing
//   reset (synchronous, active low): dividers and counters zero, all
//     attenuations silent, noise control and latch zero, shifter 0x8000,
//     both channels empty
module psg_tone_noise_generator_top #(
    parameter int unsigned PEAK_LEVEL = 4200
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [14:0] level, [15] zero
);

    // level of each attenuation step, worked out at elaboration
    localparam logic [12:0] LEVEL_TABLE [16] = '{
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[0]  / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[1]  / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[2]  / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[3]  / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[4]  / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[5]  / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[6]  / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[7]  / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[8]  / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[9]  / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[10] / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[11] / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[12] / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[13] / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[14] / psg_pkg::RATIO_SCALE),
        13'(PEAK_LEVEL * psg_pkg::ATTEN_RATIO[15] / psg_pkg::RATIO_SCALE)
    };

    // input register
    logic       r_in_valid;
    logic       r_in_mode;
    logic [7:0] r_in_byte;

    // output register
    logic        r_out_valid;
    logic [14:0] r_level;

    // generator state
    logic [9:0]  r_div   [3];
    logic [9:0]  n_div   [3];
    logic [3:0]  r_attn  [4];
    logic [3:0]  n_attn  [4];
    logic [2:0]  r_noise_ctl;
    logic [2:0]  n_noise_ctl;
    logic [2:0]  r_latch;
    logic [2:0]  n_latch;
    logic [15:0] r_shift;
    logic [15:0] n_shift;

    logic        w_advance;
    logic        w_step;
    logic        w_write;
    logic [1:0]  w_chan;
    logic [9:0]  w_reload [4];
    logic        w_feedback;
    logic [14:0] w_sum;

    psg_pkg::t_chan_status w_status [4];

    // the held item moves on unless it is a tick facing a full, stalled output
    assign w_advance     = r_in_valid && (!r_in_mode || !r_out_valid || m_axis_tready);
    assign w_step        = w_advance && r_in_mode;
    assign w_write       = w_advance && !r_in_mode;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode <= s_axis_tuser[0];
            r_in_byte <= s_axis_tdata;
        end
    end

    // counter reloads, a zero divider counts as one
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_reload[i] = (r_div[i] == '0) ? 10'd1 : r_div[i];
        end
        if (r_noise_ctl[1:0] == psg_pkg::RATE_FROM_TONE2) begin
            w_reload[3] = w_reload[2];
        end else begin
            w_reload[3] = psg_pkg::NOISE_BASE_RELOAD << r_noise_ctl[1:0];
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_chan
        psg_counter u_counter (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (w_step),
            .i_reload (w_reload[g]),
            .o_status (w_status[g])
        );
    end

    // white noise taps bits 0 and 3, periodic noise recirculates bit 0
    assign w_feedback = r_noise_ctl[2] ? (r_shift[0] ^ r_shift[3]) : r_shift[0];

    // register writes and noise shift
    always_comb begin
        n_div       = r_div;
        n_attn      = r_attn;
        n_noise_ctl = r_noise_ctl;
        n_shift     = r_shift;
        n_latch     = r_in_byte[7] ? r_in_byte[6:4] : r_latch;
        w_chan      = n_latch[2:1];
        if (w_write) begin
            if (n_latch[0]) begin
                n_attn[w_chan] = r_in_byte[3:0];
            end else if (w_chan != psg_pkg::CH_NOISE) begin
                if (r_in_byte[7]) begin
                    n_div[w_chan][3:0] = r_in_byte[3:0];
                end else begin
                    n_div[w_chan][9:4] = r_in_byte[5:0];
                end
            end else begin
                // noise control write restarts the shifter
                n_noise_ctl = r_in_byte[2:0];
                n_shift     = psg_pkg::NOISE_SEED;
            end
        end else if (w_step && w_status[3].toggle && w_status[3].square) begin
            // shift on the rising edge of the noise square
            n_shift = {w_feedback, r_shift[15:1]};
        end
    end

    // summed level after this tick
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < 3; i++) begin
            if (w_status[i].square) begin
                w_sum = w_sum + {2'b00, LEVEL_TABLE[r_attn[i]]};
            end
        end
        if (n_shift[0]) begin
            w_sum = w_sum + {2'b00, LEVEL_TABLE[r_attn[3]]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_div[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_attn[i] <= psg_pkg::ATTEN_SILENT;
            end
            r_noise_ctl <= '0;
            r_latch     <= '0;
            r_shift     <= psg_pkg::NOISE_SEED;
        end else begin
            r_div       <= n_div;
            r_attn      <= n_attn;
            r_noise_ctl <= n_noise_ctl;
            if (w_write) begin
                r_latch <= n_latch;
            end
            r_shift     <= n_shift;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_level <= w_sum;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_level};

endmodule

### rtl/core/psg_counter.sv
// 10-bit down-counter with reload and square-wave output
module psg_counter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [9:0]             i_reload,
    output psg_pkg::t_chan_status  o_status
);

    logic [9:0] r_count;
    logic [9:0] n_count;
    logic       r_square;
    logic       w_toggle;

    // zero now, or zero after the decrement
    assign w_toggle = i_step && (r_count <= 10'd1);

    always_comb begin
        n_count = r_count;
        if (w_toggle) begin
            n_count = i_reload;
        end else if (i_step) begin
            n_count = r_count - 10'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_square <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_square <= r_square ^ w_toggle;
        end
    end

    assign o_status.toggle = w_toggle;
    assign o_status.square = r_square ^ w_toggle;

endmodule

### rtl/core/psg_checker.sv
// port-level checks of the sound generator, bound to its top level
module psg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled level holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output item changed");

    // the output empties right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");

    // a fresh level follows a taken tick through the input and output registers
    a_tick_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tuser[0], 2))
        else $error("output item without a tick");

    // nothing waiting on the output, so the input is never blocked
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // spare top bit of the level stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[15])
        else $error("level pad bit set");

endmodule

bind psg_tone_noise_generator_top psg_checker u_psg_checker (.*);
